/* rtl/tkps_pkg.sv */
package tkps_pkg;

   localparam int MAX_RESULTS = 5;
   localparam int CNT_W       = 3;

   typedef enum logic [2:0] {
      MODE_NORMAL  = 3'd0,
      MODE_SEP     = 3'd1,
      MODE_LIT     = 3'd2,
      MODE_BASIC   = 3'd3,
      MODE_IDX     = 3'd4,
      MODE_IDX_END = 3'd5
   } mode_type;

   typedef enum logic [2:0] {
      KIND_BYTE    = 3'd0,
      KIND_DOT     = 3'd1,
      KIND_BRACKET = 3'd2,
      KIND_END     = 3'd3,
      KIND_ERROR   = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      ESC_NONE      = 2'd0,
      ESC_BACKSLASH = 2'd1,
      ESC_HEX       = 2'd2
   } esc_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [2:0] result_kind;
      logic       run_end;
   } rsp_type;

   // results caused by one input byte
   typedef struct packed {
      logic [CNT_W-1:0]                  count;
      logic [MAX_RESULTS-1:0][7:0]       bytes;
      kind_type [MAX_RESULTS-1:0]        kinds;
   } rlist_type;

endpackage

/* rtl/toml_key_path_splitter_top.sv */
// Latency: results of a byte appear on rsp the cycle after its req transfer.
// Throughput: one byte per cycle while each byte gives at most one result and rsp
//   is not stalled; a byte giving N results (up to five, e.g. a \U escape closing
//   on the last byte) holds req while the buffer drains one entry per rsp transfer.
// Reset: synchronous, active high; clears parser state and drops buffered results.
module toml_key_path_splitter_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tkps_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tkps_pkg::rsp_type rsp_data
);
   import tkps_pkg::*;

   // Result buffer: the list of results of the most recent byte,
   // read out one entry per rsp transfer.
   rlist_type        list_in;
   logic [MAX_RESULTS-1:0][7:0] bytes_ff;
   kind_type [MAX_RESULTS-1:0]  kinds_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] idx_ff, idx_in;

   logic take;       // rsp transfer this cycle
   logic last_take;  // rsp transfer of the buffer's final entry
   logic accept;     // req transfer this cycle
   logic [CNT_W-1:0] idx_next;

   assign idx_next  = idx_ff + 3'd1;
   assign rsp_valid = (idx_ff < cnt_ff);
   assign take      = rsp_valid && !rsp_stall;
   assign last_take = take && (idx_next == cnt_ff);
   // buffer can be refilled when empty or emptying this cycle
   assign req_stall = rsp_valid && !last_take;
   assign accept    = req_valid && !req_stall;

   tkps_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .accept   (accept),
      .list     (list_in)
   );

   always_comb begin
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      if (accept) begin
         cnt_in = list_in.count;
         idx_in = '0;
      end else if (last_take) begin
         cnt_in = '0;
         idx_in = '0;
      end else if (take) begin
         idx_in = idx_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         idx_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
      end
   end

   // payload only: no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         bytes_ff <= list_in.bytes;
         kinds_ff <= list_in.kinds;
      end
   end

   // out_byte is zero on non-byte kinds, guaranteed by the decoder
   assign rsp_data.out_byte    = bytes_ff[idx_ff];
   assign rsp_data.result_kind = kinds_ff[idx_ff];
   assign rsp_data.run_end     = (idx_next == cnt_ff);

endmodule

/* rtl/tkps_decode.sv */
module tkps_decode (
   input  logic               clock,
   input  logic               reset,
   input  tkps_pkg::req_type  req_data,
   input  logic               accept,
   output tkps_pkg::rlist_type list
);
   import tkps_pkg::*;

   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_USCORE = 8'h5F;

   mode_type    mode_ff, mode_in;
   logic        nonempty_ff, nonempty_in;
   esc_type     esc_ff, esc_in;
   logic [3:0]  hex_left_ff, hex_left_in;
   logic [31:0] hex_val_ff, hex_val_in;
   logic        hex_stop_ff, hex_stop_in;
   logic        hex_seen_ff, hex_seen_in;
   logic        err_ff, err_in;

   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return {1'b0, c[3:0]};
      if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
         return {1'b0, c[3:0] + 4'd9};
      return 5'h10;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_alnum(input logic [7:0] c);
      return is_digit(c) || (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   endfunction

   always_comb begin
      logic [7:0]  c;
      logic [4:0]  d;
      logic [31:0] v;
      logic        quoted;
      logic        sep_ok;
      logic        hex_fail;
      mode_type    own;
      mode_type    other;
      c           = req_data.in_byte;
      mode_in     = mode_ff;
      nonempty_in = nonempty_ff;
      esc_in      = esc_ff;
      hex_left_in = hex_left_ff;
      hex_val_in  = hex_val_ff;
      hex_stop_in = hex_stop_ff;
      hex_seen_in = hex_seen_ff;
      err_in      = err_ff;
      list        = '0;
      d           = hex_digit(c);
      v           = '0;
      hex_fail    = 1'b0;
      quoted      = (mode_ff == MODE_LIT) || (mode_ff == MODE_BASIC);
      sep_ok      = (mode_ff == MODE_NORMAL) || (mode_ff == MODE_SEP);
      own         = (c == CH_SQUOTE) ? MODE_LIT : MODE_BASIC;
      other       = (c == CH_SQUOTE) ? MODE_BASIC : MODE_LIT;

      if (!err_ff) begin
         if (esc_ff == ESC_HEX) begin
            if (!hex_stop_ff) begin
               if (d[4]) begin
                  if (!hex_seen_ff) begin
                     hex_fail = 1'b1;
                  end else begin
                     hex_stop_in = 1'b1;
                  end
               end else begin
                  hex_val_in  = {hex_val_ff[27:0], d[3:0]};
                  hex_seen_in = 1'b1;
                  if (hex_val_in[31:28] != 4'd0) hex_stop_in = 1'b1;
               end
            end
            if (hex_fail) begin
               list.kinds[0] = KIND_ERROR;
               list.count    = 3'd1;
               err_in        = 1'b1;
            end else begin
               if (hex_left_ff != 4'd0) hex_left_in = hex_left_ff - 4'd1;
               if (hex_left_in == 4'd0) begin
                  // window done: encode as UTF-8, or flag an error above U+10FFFF
                  v      = hex_val_in;
                  esc_in = ESC_NONE;
                  if (v < 32'h80) begin
                     list.bytes[0] = v[7:0];
                     list.count    = 3'd1;
                  end else if (v < 32'h800) begin
                     list.bytes[0] = {3'b110, v[10:6]};
                     list.bytes[1] = {2'b10, v[5:0]};
                     list.count    = 3'd2;
                  end else if (v < 32'h10000) begin
                     list.bytes[0] = {4'b1110, v[15:12]};
                     list.bytes[1] = {2'b10, v[11:6]};
                     list.bytes[2] = {2'b10, v[5:0]};
                     list.count    = 3'd3;
                  end else if (v < 32'h110000) begin
                     list.bytes[0] = {5'b11110, v[20:18]};
                     list.bytes[1] = {2'b10, v[17:12]};
                     list.bytes[2] = {2'b10, v[11:6]};
                     list.bytes[3] = {2'b10, v[5:0]};
                     list.count    = 3'd4;
                  end else begin
                     list.kinds[0] = KIND_ERROR;
                     list.count    = 3'd1;
                     err_in        = 1'b1;
                  end
                  if (!err_in) nonempty_in = 1'b1;
               end
            end
         end else if (esc_ff == ESC_BACKSLASH) begin
            esc_in     = ESC_NONE;
            list.count = 3'd1;
            case (c) inside
               8'h62: list.bytes[0] = 8'h08;
               8'h74: list.bytes[0] = 8'h09;
               8'h6E: list.bytes[0] = 8'h0A;
               8'h66: list.bytes[0] = 8'h0C;
               8'h72: list.bytes[0] = 8'h0D;
               CH_DQUOTE, CH_BSLASH: list.bytes[0] = c;
               8'h75, 8'h55: begin
                  list.count  = 3'd0;
                  esc_in      = ESC_HEX;
                  hex_left_in = (c == 8'h75) ? 4'd4 : 4'd8;
                  hex_val_in  = '0;
                  hex_stop_in = 1'b0;
                  hex_seen_in = 1'b0;
               end
               default: begin
                  list.kinds[0] = KIND_ERROR;
                  err_in        = 1'b1;
               end
            endcase
            if (list.count != 3'd0 && !err_in) nonempty_in = 1'b1;
         end else begin
            case (c) inside
               CH_SPACE, CH_TAB: begin
                  if (quoted) begin
                     list.bytes[0] = c;
                     list.count    = 3'd1;
                     nonempty_in   = 1'b1;
                  end else if (mode_ff == MODE_NORMAL && nonempty_ff) begin
                     mode_in = MODE_SEP;
                  end
               end
               CH_CR, CH_LF: begin
                  if (mode_ff == MODE_NORMAL && nonempty_ff) mode_in = MODE_SEP;
               end
               CH_SQUOTE, CH_DQUOTE: begin
                  if (mode_ff == MODE_NORMAL && !nonempty_ff) begin
                     mode_in = own;
                  end else if (mode_ff == own) begin
                     mode_in = MODE_SEP;
                  end else if (mode_ff == other) begin
                     list.bytes[0] = c;
                     list.count    = 3'd1;
                     nonempty_in   = 1'b1;
                  end else begin
                     list.kinds[0] = KIND_ERROR;
                     list.count    = 3'd1;
                     err_in        = 1'b1;
                  end
               end
               CH_BSLASH: begin
                  if (mode_ff == MODE_LIT) begin
                     list.bytes[0] = c;
                     list.count    = 3'd1;
                     nonempty_in   = 1'b1;
                  end else if (mode_ff == MODE_BASIC) begin
                     esc_in = ESC_BACKSLASH;
                  end else begin
                     list.kinds[0] = KIND_ERROR;
                     list.count    = 3'd1;
                     err_in        = 1'b1;
                  end
               end
               CH_DOT: begin
                  if (quoted) begin
                     list.bytes[0] = c;
                     list.count    = 3'd1;
                     nonempty_in   = 1'b1;
                  end else if (nonempty_ff) begin
                     list.count = 3'd1;
                     if (!sep_ok) begin
                        list.kinds[0] = KIND_ERROR;
                        err_in        = 1'b1;
                     end else begin
                        list.kinds[0] = KIND_DOT;
                        mode_in       = MODE_NORMAL;
                        nonempty_in   = 1'b0;
                     end
                  end
               end
               CH_LBRACK: begin
                  if (quoted) begin
                     list.bytes[0] = c;
                     list.count    = 3'd1;
                     nonempty_in   = 1'b1;
                  end else if (!sep_ok) begin
                     list.kinds[0] = KIND_ERROR;
                     list.count    = 3'd1;
                     err_in        = 1'b1;
                  end else begin
                     if (nonempty_ff) begin
                        list.kinds[0] = KIND_BRACKET;
                        list.count    = 3'd1;
                        nonempty_in   = 1'b0;
                     end
                     mode_in = MODE_IDX;
                  end
               end
               CH_RBRACK: begin
                  if (quoted) begin
                     list.bytes[0] = c;
                     list.count    = 3'd1;
                     nonempty_in   = 1'b1;
                  end else if (mode_ff != MODE_IDX_END) begin
                     list.kinds[0] = KIND_ERROR;
                     list.count    = 3'd1;
                     err_in        = 1'b1;
                  end else begin
                     mode_in = MODE_SEP;
                  end
               end
               default: begin
                  list.count = 3'd1;
                  if (quoted) begin
                     list.bytes[0] = c;
                     nonempty_in   = 1'b1;
                  end else if ((mode_ff == MODE_IDX || mode_ff == MODE_IDX_END)
                               && is_digit(c)) begin
                     list.bytes[0] = c;
                     nonempty_in   = 1'b1;
                     mode_in       = MODE_IDX_END;
                  end else if (mode_ff == MODE_NORMAL &&
                               (is_alnum(c) || c == CH_DASH || c == CH_USCORE)) begin
                     list.bytes[0] = c;
                     nonempty_in   = 1'b1;
                  end else begin
                     list.kinds[0] = KIND_ERROR;
                     err_in        = 1'b1;
                  end
               end
            endcase
         end
      end

      // closing byte: end or error unless an error was already given, then back to reset state
      if (req_data.last) begin
         if (!err_in) begin
            if (esc_in != ESC_NONE || mode_in == MODE_LIT || mode_in == MODE_BASIC ||
                mode_in == MODE_IDX || mode_in == MODE_IDX_END) begin
               list.kinds[list.count] = KIND_ERROR;
            end else begin
               list.kinds[list.count] = KIND_END;
            end
            list.count = list.count + 3'd1;
         end
         mode_in     = MODE_NORMAL;
         nonempty_in = 1'b0;
         esc_in      = ESC_NONE;
         hex_left_in = '0;
         hex_val_in  = '0;
         hex_stop_in = 1'b0;
         hex_seen_in = 1'b0;
         err_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_NORMAL;
         nonempty_ff <= 1'b0;
         esc_ff      <= ESC_NONE;
         hex_left_ff <= '0;
         hex_val_ff  <= '0;
         hex_stop_ff <= 1'b0;
         hex_seen_ff <= 1'b0;
         err_ff      <= 1'b0;
      end else if (accept) begin
         mode_ff     <= mode_in;
         nonempty_ff <= nonempty_in;
         esc_ff      <= esc_in;
         hex_left_ff <= hex_left_in;
         hex_val_ff  <= hex_val_in;
         hex_stop_ff <= hex_stop_in;
         hex_seen_ff <= hex_seen_in;
         err_ff      <= err_in;
      end
   end

endmodule
